// ===== hw/rtl/mass_spring_lattice_euler_step_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MASS_SPRING_LATTICE_EULER_STEP_MACROS_SVH
`define MASS_SPRING_LATTICE_EULER_STEP_MACROS_SVH

`ifndef NO_ASSERTIONS

`define MSL_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define MSL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define MSL_ASSERT_SAME(label, ante, cons, msg)

`define MSL_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/msl_pkg.sv =====
// ----------------------------------------------------------------------------
// msl_pkg
// Types, codes and fixed-point helpers of the lattice Euler step block.
// ----------------------------------------------------------------------------
package msl_pkg;

	localparam int CFW = 20;

	// register indexes
	localparam logic [2:0] REG_SPRING_K     = 3'd0;
	localparam logic [2:0] REG_DAMPER_B     = 3'd1;
	localparam logic [2:0] REG_INVERSE_MASS = 3'd2;
	localparam logic [2:0] REG_TIME_STEP    = 3'd3;
	localparam logic [2:0] REG_TOP_WALL     = 3'd4;

	localparam logic [CFW-1:0] RST_SPRING_K     = 20'd13107;
	localparam logic [CFW-1:0] RST_DAMPER_B     = 20'd3277;
	localparam logic [CFW-1:0] RST_INVERSE_MASS = 20'd65536;
	localparam logic [CFW-1:0] RST_TIME_STEP    = 20'd3277;

	// datapath operations
	localparam logic [3:0] OP_NONE = 4'd0;
	localparam logic [3:0] OP_MK   = 4'd1;
	localparam logic [3:0] OP_MB   = 4'd2;
	localparam logic [3:0] OP_SB   = 4'd3;
	localparam logic [3:0] OP_SF   = 4'd4;
	localparam logic [3:0] OP_MI   = 4'd5;
	localparam logic [3:0] OP_SA   = 4'd6;
	localparam logic [3:0] OP_MA   = 4'd7;
	localparam logic [3:0] OP_RA   = 4'd8;
	localparam logic [3:0] OP_NV   = 4'd9;
	localparam logic [3:0] OP_ND   = 4'd10;

	localparam logic [2:0] LINK_SELF = 3'd0;
	localparam logic [2:0] LINK_LAST = 3'd6;
	localparam logic [1:0] AXIS_LAST = 2'd2;

	typedef struct packed {
		logic       clr_step;
		logic       load_in;
		logic       rd_en;
		logic [2:0] link;
		logic [1:0] axis;
		logic [3:0] op;
		logic       load_out;
	} msl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic out_busy;
	} msl_stat_t;

	localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] SAT_MIN = -64'sh0000_0000_8000_0000;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > SAT_MAX) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < SAT_MIN) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/msl_ctrl.sv =====
// ----------------------------------------------------------------------------
// msl_ctrl
// Sequencer: clearing pass, neighbor reads and multiply steps per axis.
// ----------------------------------------------------------------------------
`include "mass_spring_lattice_euler_step_macros.svh"

module msl_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  msl_pkg::msl_stat_t  st,
	output msl_pkg::msl_cmd_t   cmd
);

	localparam logic [3:0] ST_CLR  = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_RD   = 4'd2;
	localparam logic [3:0] ST_WT   = 4'd3;
	localparam logic [3:0] ST_MK   = 4'd4;
	localparam logic [3:0] ST_MB   = 4'd5;
	localparam logic [3:0] ST_SB   = 4'd6;
	localparam logic [3:0] ST_SF   = 4'd7;
	localparam logic [3:0] ST_MI   = 4'd8;
	localparam logic [3:0] ST_SA   = 4'd9;
	localparam logic [3:0] ST_MA   = 4'd10;
	localparam logic [3:0] ST_RA   = 4'd11;
	localparam logic [3:0] ST_NV   = 4'd12;
	localparam logic [3:0] ST_ND   = 4'd13;
	localparam logic [3:0] ST_FIN  = 4'd14;

	logic [3:0] state_q, state_d;
	logic [2:0] link_q, link_d;
	logic [1:0] axis_q, axis_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d      = state_q;
		link_d       = link_q;
		axis_d       = axis_q;
		cmd          = '0;
		cmd.link     = link_q;
		cmd.axis     = axis_q;
		cmd.op       = msl_pkg::OP_NONE;
		unique case (state_q)
			ST_CLR: begin
				cmd.clr_step = 1'b1;
				if (st.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					axis_d      = 2'd0;
					link_d      = msl_pkg::LINK_SELF;
					state_d     = ST_RD;
				end
			end
			ST_RD: begin
				cmd.rd_en = 1'b1;
				if (link_q == msl_pkg::LINK_LAST) begin
					state_d = ST_WT;
				end else begin
					link_d = link_q + 3'd1;
				end
			end
			ST_WT: state_d = ST_MK;
			ST_MK: begin
				cmd.op  = msl_pkg::OP_MK;
				state_d = ST_MB;
			end
			ST_MB: begin
				cmd.op  = msl_pkg::OP_MB;
				state_d = ST_SB;
			end
			ST_SB: begin
				cmd.op  = msl_pkg::OP_SB;
				state_d = ST_SF;
			end
			ST_SF: begin
				cmd.op  = msl_pkg::OP_SF;
				state_d = ST_MI;
			end
			ST_MI: begin
				cmd.op  = msl_pkg::OP_MI;
				state_d = ST_SA;
			end
			ST_SA: begin
				cmd.op  = msl_pkg::OP_SA;
				state_d = ST_MA;
			end
			ST_MA: begin
				cmd.op  = msl_pkg::OP_MA;
				state_d = ST_RA;
			end
			ST_RA: begin
				cmd.op  = msl_pkg::OP_RA;
				state_d = ST_NV;
			end
			ST_NV: begin
				cmd.op  = msl_pkg::OP_NV;
				state_d = ST_ND;
			end
			ST_ND: begin
				cmd.op = msl_pkg::OP_ND;
				if (axis_q == msl_pkg::AXIS_LAST) begin
					state_d = ST_FIN;
				end else begin
					axis_d  = axis_q + 2'd1;
					link_d  = msl_pkg::LINK_SELF;
					state_d = ST_RD;
				end
			end
			ST_FIN: begin
				if (!st.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_CLR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			link_q  <= '0;
			axis_q  <= '0;
		end else begin
			state_q <= state_d;
			link_q  <= link_d;
			axis_q  <= axis_d;
		end
	end

	`MSL_ASSERT_NEXT(a_accept_starts_read, s_tvalid && s_tready,
		state_q == ST_RD && link_q == msl_pkg::LINK_SELF && axis_q == 2'd0,
		"accepted beat did not start the self read")
	`MSL_ASSERT_NEXT(a_reads_then_wait, state_q == ST_RD && link_q == msl_pkg::LINK_LAST,
		state_q == ST_WT, "read sequence did not end after the last link")
	`MSL_ASSERT_SAME(a_axis_range, state_q != ST_CLR && state_q != ST_IDLE,
		axis_q != 2'd3, "axis counter out of range")

endmodule

// ===== hw/rtl/msl_dp.sv =====
// ----------------------------------------------------------------------------
// msl_dp
// Datapath: state memories, neighbor accumulation, shared multiplier,
// rounding and saturation, output register.
// ----------------------------------------------------------------------------
module msl_dp #(
	parameter int GRID_X = 15,
	parameter int GRID_Y = 6,
	parameter int GRID_Z = 3
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  msl_pkg::msl_cmd_t      cmd,
	output msl_pkg::msl_stat_t     st,
	input  logic [95:0]            s_tdata,
	input  logic                   m_tready,
	output logic                   m_tvalid,
	output logic [191:0]           m_tdata,
	output logic                   m_tuser,
	input  logic [19:0]            spring_k,
	input  logic [19:0]            damper_b,
	input  logic [19:0]            inverse_mass,
	input  logic [19:0]            time_step,
	input  logic                   top_wall_open
);

	localparam int N  = GRID_X * GRID_Y * GRID_Z;
	localparam int CW = (N > 1) ? $clog2(N) : 1;
	localparam int XW = (GRID_X > 1) ? $clog2(GRID_X) : 1;
	localparam int YW = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
	localparam int ZW = (GRID_Z > 1) ? $clog2(GRID_Z) : 1;
	localparam int AW = $clog2(6 * N);
	localparam int DEPTH = 6 * N;

	localparam logic [AW-1:0] D_Z = AW'(1);
	localparam logic [AW-1:0] D_X = AW'(GRID_Z);
	localparam logic [AW-1:0] D_Y = AW'(GRID_Z * GRID_X);
	localparam logic [AW-1:0] BANK_OFS = AW'(3 * N);
	localparam logic [AW-1:0] AX1_OFS = AW'(N);
	localparam logic [AW-1:0] AX2_OFS = AW'(2 * N);
	localparam logic [AW-1:0] CLR_END = AW'(3 * N - 1);

	// lattice position
	logic [CW-1:0] c_q;
	logic [XW-1:0] x_q;
	logic [YW-1:0] y_q;
	logic [ZW-1:0] z_q;
	logic          bank_q;
	logic [AW-1:0] clr_q;
	logic          last_mass;

	logic [5:0] ins;
	logic       top_skip;

	assign last_mass = (c_q == CW'(N - 1));
	assign ins[0] = (z_q != '0);
	assign ins[1] = (z_q != ZW'(GRID_Z - 1));
	assign ins[2] = (x_q != '0);
	assign ins[3] = (x_q != XW'(GRID_X - 1));
	assign ins[4] = (y_q != '0);
	assign ins[5] = (y_q != YW'(GRID_Y - 1));
	assign top_skip = !ins[5] && top_wall_open;

	// addresses
	logic [AW-1:0] ax_ofs, rd_base, wr_base, cw, nidx, rd_addr, wr_addr, mem_waddr;
	logic          link_wall, link_skip;

	always_comb begin
		case (cmd.axis)
			2'd1:    ax_ofs = AX1_OFS;
			2'd2:    ax_ofs = AX2_OFS;
			default: ax_ofs = '0;
		endcase
		cw      = AW'(c_q);
		rd_base = (bank_q ? BANK_OFS : '0) + ax_ofs;
		wr_base = (bank_q ? '0 : BANK_OFS) + ax_ofs;
		link_wall = 1'b0;
		link_skip = 1'b0;
		case (cmd.link)
			3'd1: begin nidx = cw - D_Z; link_wall = !ins[0]; end
			3'd2: begin nidx = cw + D_Z; link_wall = !ins[1]; end
			3'd3: begin nidx = cw - D_X; link_wall = !ins[2]; end
			3'd4: begin nidx = cw + D_X; link_wall = !ins[3]; end
			3'd5: begin nidx = cw - D_Y; link_wall = !ins[4]; end
			3'd6: begin
				nidx      = cw + D_Y;
				link_wall = !ins[5];
				link_skip = top_skip;
			end
			default: nidx = cw;
		endcase
		rd_addr = rd_base + nidx;
		wr_addr = wr_base + cw;
	end

	// state memories
	logic [31:0] disp_mem [DEPTH];
	logic [31:0] vel_mem [DEPTH];
	logic [31:0] xrd_q, vrd_q;
	logic        mem_we;
	logic [31:0] wd_disp, wd_vel;

	logic signed [31:0] dnew;
	logic signed [31:0] vnew_q;

	assign mem_we    = cmd.clr_step || (cmd.op == msl_pkg::OP_ND);
	assign mem_waddr = cmd.clr_step ? clr_q : wr_addr;
	assign wd_disp   = cmd.clr_step ? '0 : dnew;
	assign wd_vel    = cmd.clr_step ? '0 : vnew_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			disp_mem[mem_waddr] <= wd_disp;
			vel_mem[mem_waddr]  <= wd_vel;
		end
		xrd_q <= disp_mem[rd_addr];
		vrd_q <= vel_mem[rd_addr];
	end

	// read pipeline control
	logic       rd_s1, wall_s1, skip_s1;
	logic [2:0] link_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= cmd.rd_en;
		end
	end

	always_ff @(posedge clk) begin
		link_s1 <= cmd.link;
		wall_s1 <= link_wall;
		skip_s1 <= link_skip;
	end

	// arithmetic
	logic signed [31:0] force_q [3];
	logic signed [31:0] x0_q, v0_q, f_q, a_q;
	logic signed [35:0] dx_q, dv_q;
	logic signed [59:0] s_q;
	logic signed [56:0] prod_q;
	logic signed [40:0] r_q;

	logic signed [31:0] xn, vn;
	logic signed [35:0] mul_a;
	logic signed [20:0] mul_b;
	logic signed [56:0] mul_p;
	logic signed [59:0] s_rnd;
	logic signed [56:0] p_rnd;
	logic signed [41:0] v_sum, d_sum;

	assign xn = wall_s1 ? '0 : $signed(xrd_q);
	assign vn = wall_s1 ? '0 : $signed(vrd_q);

	always_comb begin
		case (cmd.op)
			msl_pkg::OP_MB: begin mul_a = dv_q; mul_b = $signed({1'b0, damper_b}); end
			msl_pkg::OP_MI: begin
				mul_a = 36'(f_q);
				mul_b = $signed({1'b0, inverse_mass});
			end
			msl_pkg::OP_MA: begin mul_a = 36'(a_q); mul_b = $signed({1'b0, time_step}); end
			msl_pkg::OP_RA: begin mul_a = 36'(v0_q); mul_b = $signed({1'b0, time_step}); end
			default:        begin mul_a = dx_q; mul_b = $signed({1'b0, spring_k}); end
		endcase
		mul_p = mul_a * mul_b;
		s_rnd = s_q + 60'sd32768;
		p_rnd = prod_q + 57'sd32768;
		v_sum = 42'(v0_q) + 42'(r_q);
		d_sum = 42'(x0_q) + 42'(r_q);
		dnew  = msl_pkg::sat32(64'(d_sum));
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			force_q[0] <= s_tdata[31:0];
			force_q[1] <= s_tdata[63:32];
			force_q[2] <= s_tdata[95:64];
		end
		if (rd_s1) begin
			if (link_s1 == msl_pkg::LINK_SELF) begin
				x0_q <= $signed(xrd_q);
				v0_q <= $signed(vrd_q);
				dx_q <= '0;
				dv_q <= '0;
			end else if (!skip_s1) begin
				dx_q <= dx_q + 36'(xn) - 36'(x0_q);
				dv_q <= dv_q + 36'(vn) - 36'(v0_q);
			end
		end
		case (cmd.op)
			msl_pkg::OP_MK: prod_q <= mul_p;
			msl_pkg::OP_MB: begin
				prod_q <= mul_p;
				s_q    <= {{12{force_q[cmd.axis][31]}}, force_q[cmd.axis], 16'd0}
					+ 60'(prod_q);
			end
			msl_pkg::OP_SB: s_q <= s_q + 60'(prod_q);
			msl_pkg::OP_SF: f_q <= msl_pkg::sat32(64'($signed(s_rnd[59:16])));
			msl_pkg::OP_MI: prod_q <= mul_p;
			msl_pkg::OP_SA: a_q <= msl_pkg::sat32(64'($signed(p_rnd[56:16])));
			msl_pkg::OP_MA: prod_q <= mul_p;
			msl_pkg::OP_RA: begin
				r_q    <= p_rnd[56:16];
				prod_q <= mul_p;
			end
			msl_pkg::OP_NV: begin
				vnew_q <= msl_pkg::sat32(64'(v_sum));
				r_q    <= p_rnd[56:16];
			end
			default: ;
		endcase
	end

	// per-axis results and output register
	logic [31:0] dres_q [3];
	logic [31:0] vres_q [3];
	logic        out_vld_q;

	always_ff @(posedge clk) begin
		if (cmd.op == msl_pkg::OP_ND) begin
			dres_q[cmd.axis] <= dnew;
			vres_q[cmd.axis] <= vnew_q;
		end
		if (cmd.load_out) begin
			m_tdata <= {vres_q[2], vres_q[1], vres_q[0], dres_q[2], dres_q[1], dres_q[0]};
			m_tuser <= last_mass;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			c_q       <= '0;
			x_q       <= '0;
			y_q       <= '0;
			z_q       <= '0;
			bank_q    <= 1'b0;
			clr_q     <= '0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.load_out) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			if (cmd.load_out) begin
				if (last_mass) begin
					c_q    <= '0;
					x_q    <= '0;
					y_q    <= '0;
					z_q    <= '0;
					bank_q <= !bank_q;
				end else begin
					c_q <= c_q + CW'(1);
					if (z_q == ZW'(GRID_Z - 1)) begin
						z_q <= '0;
						if (x_q == XW'(GRID_X - 1)) begin
							x_q <= '0;
							y_q <= y_q + YW'(1);
						end else begin
							x_q <= x_q + XW'(1);
						end
					end else begin
						z_q <= z_q + ZW'(1);
					end
				end
			end
		end
	end

	assign m_tvalid    = out_vld_q;
	assign st.out_busy = out_vld_q && !m_tready;
	assign st.clr_last = (clr_q == CLR_END);

endmodule

// ===== hw/rtl/mass_spring_lattice_euler_step.sv =====
// ----------------------------------------------------------------------------
// mass_spring_lattice_euler_step
// Explicit Euler step of a 3-D spring-damper lattice, one mass per beat.
//
// channel  dir  width  content
// s_*      in   96     force_x, force_y, force_z
// m_*      out  192+1  disp_x..z, vel_x..z; tuser step_done
// apb      in   32     spring_k, damper_b, inverse_mass, time_step, top_wall_open
//
// each mass runs per axis seven memory reads (self and six links), a wait state,
// then ten steps through the single shared multiplier and rounding stages
// after reset a clearing pass zeroes all 3*GRID_X*GRID_Y*GRID_Z entries of the
// first bank, with s_tready low
// a new beat is taken while the previous result waits in the output register
// ----------------------------------------------------------------------------
module mass_spring_lattice_euler_step #(
	parameter int GRID_X = 15,
	parameter int GRID_Y = 6,
	parameter int GRID_Z = 3
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,   // force_x, force_y, force_z
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [191:0] m_tdata,   // disp_x, disp_y, disp_z, vel_x, vel_y, vel_z
	output logic         m_tuser,   // step_done
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	logic [19:0] spring_k_q, damper_b_q, inverse_mass_q, time_step_q;
	logic        top_wall_q;
	logic        cfg_we;
	logic [2:0]  reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_we  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spring_k_q     <= msl_pkg::RST_SPRING_K;
			damper_b_q     <= msl_pkg::RST_DAMPER_B;
			inverse_mass_q <= msl_pkg::RST_INVERSE_MASS;
			time_step_q    <= msl_pkg::RST_TIME_STEP;
			top_wall_q     <= 1'b1;
		end else if (cfg_we) begin
			unique case (reg_idx)
				msl_pkg::REG_SPRING_K:     spring_k_q     <= pwdata[19:0];
				msl_pkg::REG_DAMPER_B:     damper_b_q     <= pwdata[19:0];
				msl_pkg::REG_INVERSE_MASS: inverse_mass_q <= pwdata[19:0];
				msl_pkg::REG_TIME_STEP:    time_step_q    <= pwdata[19:0];
				msl_pkg::REG_TOP_WALL:     top_wall_q     <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			msl_pkg::REG_SPRING_K:     prdata = {12'd0, spring_k_q};
			msl_pkg::REG_DAMPER_B:     prdata = {12'd0, damper_b_q};
			msl_pkg::REG_INVERSE_MASS: prdata = {12'd0, inverse_mass_q};
			msl_pkg::REG_TIME_STEP:    prdata = {12'd0, time_step_q};
			msl_pkg::REG_TOP_WALL:     prdata = {31'd0, top_wall_q};
			default:                   prdata = '0;
		endcase
	end

	msl_pkg::msl_cmd_t  cmd;
	msl_pkg::msl_stat_t st;

	msl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	msl_dp #(
		.GRID_X (GRID_X),
		.GRID_Y (GRID_Y),
		.GRID_Z (GRID_Z)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.s_tdata       (s_tdata),
		.m_tready      (m_tready),
		.m_tvalid      (m_tvalid),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.spring_k      (spring_k_q),
		.damper_b      (damper_b_q),
		.inverse_mass  (inverse_mass_q),
		.time_step     (time_step_q),
		.top_wall_open (top_wall_q)
	);

endmodule
